[rtl/tlvd_pkg.sv]
// Shared types and constants of the type-length-value stream deframer.
package tlvd_pkg;

  localparam logic [7:0] LEN_EXT16 = 8'd126;
  localparam logic [7:0] LEN_EXT64 = 8'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] type_tag;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        object_last;
  } result_t;

endpackage

[rtl/tlv_stream_deframer_unit.sv]
// Top level of the type-length-value stream deframer.
//
// The input channel carries one stream byte per beat on data_byte, with
// data_valid and data_stall. Each object is a little-endian type tag of
// TYPE_BYTES bytes, then a length prefix byte; prefix 126 is followed by a
// 16-bit and prefix 127 by a 64-bit little-endian length.
// The result channel (result_valid, result_stall) gives one header beat per
// object with its tag and length, then one beat per payload byte; the final
// beat of an object has object_last set. A zero length ends the object at
// its header. Tag bytes and extended length bytes give no result.
// A byte is accepted every cycle while data_stall is low; its result, if any,
// is registered in the output or skid register. The parser state update is a
// single registered step per byte, bounded by the 64-bit remaining-byte
// decrement and compare. A skid register behind the output register holds
// one result while the receiver stalls, so data_stall rises only after two
// results are waiting. Synchronous reset returns the parser to the start of
// an object and empties both result registers.
module tlv_stream_deframer_unit #(
  parameter int TYPE_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [31:0] type_tag,
  output logic [63:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        object_last
);

  localparam int TagIdxW = (TYPE_BYTES > 1) ? $clog2(TYPE_BYTES) : 1;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_DATA
  } phase_t;

  phase_t               phase, phase_next;
  logic [31:0]          tag, tag_next;
  logic [TagIdxW-1:0]   tag_idx, tag_idx_next;
  logic [3:0]           len_cnt, len_cnt_next;
  logic                 ext16, ext16_next;
  logic [63:0]          accum, accum_next;
  logic [63:0]          remaining, remaining_next;

  logic                 accept;
  logic                 res_valid;
  tlvd_pkg::result_t    res;
  logic                 header;

  tlvd_pkg::result_t    out_reg;
  logic                 out_valid;
  tlvd_pkg::result_t    skid_reg;
  logic                 skid_valid;
  logic                 out_free;

  assign accept = data_valid && !data_stall;

  always_comb begin
    phase_next     = phase;
    tag_next       = tag;
    tag_idx_next   = tag_idx;
    len_cnt_next   = len_cnt;
    ext16_next     = ext16;
    accum_next     = accum;
    remaining_next = remaining;
    header         = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    case (phase)
      PH_LEN: begin
        if (len_cnt == 4'd0) begin
          if (data_byte == tlvd_pkg::LEN_EXT16 || data_byte == tlvd_pkg::LEN_EXT64) begin
            ext16_next   = (data_byte == tlvd_pkg::LEN_EXT16);
            accum_next   = '0;
            len_cnt_next = 4'd1;
          end else begin
            accum_next = {56'd0, data_byte};
            header     = 1'b1;
          end
        end else begin
          accum_next[(3'(len_cnt - 4'd1)) * 8 +: 8] = data_byte;
          len_cnt_next = len_cnt + 4'd1;
          if (ext16 ? (len_cnt == tlvd_pkg::EXT16_BYTES)
                    : (len_cnt == tlvd_pkg::EXT64_BYTES)) begin
            header = 1'b1;
          end
        end
        if (header) begin
          res_valid          = 1'b1;
          res.kind           = tlvd_pkg::KIND_HEADER;
          res.type_tag       = tag;
          res.payload_length = accum_next;
          res.payload_byte   = 8'd0;
          res.object_last    = (accum_next == 64'd0);
          len_cnt_next       = 4'd0;
          if (accum_next == 64'd0) begin
            phase_next   = PH_TYPE;
            tag_next     = '0;
            tag_idx_next = '0;
          end else begin
            phase_next     = PH_DATA;
            remaining_next = accum_next;
          end
        end
      end
      PH_DATA: begin
        res_valid          = 1'b1;
        res.kind           = tlvd_pkg::KIND_PAYLOAD;
        res.type_tag       = tag;
        res.payload_length = accum;
        res.payload_byte   = data_byte;
        res.object_last    = (remaining == 64'd1);
        remaining_next     = remaining - 64'd1;
        if (remaining == 64'd1) begin
          phase_next   = PH_TYPE;
          tag_next     = '0;
          tag_idx_next = '0;
        end
      end
      default: begin
        tag_next[tag_idx * 8 +: 8] = data_byte;
        if (tag_idx == TagIdxW'(TYPE_BYTES - 1)) begin
          phase_next   = PH_LEN;
          tag_idx_next = '0;
          len_cnt_next = 4'd0;
        end else begin
          tag_idx_next = tag_idx + TagIdxW'(1);
        end
      end
    endcase
  end

  assign out_free = !out_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      tag        <= '0;
      tag_idx    <= '0;
      len_cnt    <= 4'd0;
      ext16      <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        tag       <= tag_next;
        tag_idx   <= tag_idx_next;
        len_cnt   <= len_cnt_next;
        ext16     <= ext16_next;
        accum     <= accum_next;
        remaining <= remaining_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_reg   <= res;
          out_valid <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign data_stall     = skid_valid;
  assign result_valid   = out_valid;
  assign kind           = out_reg.kind;
  assign type_tag       = out_reg.type_tag;
  assign payload_length = out_reg.payload_length;
  assign payload_byte   = out_reg.payload_byte;
  assign object_last    = out_reg.object_last;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid register holds a result while the output register is empty.");

  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind == tlvd_pkg::KIND_HEADER) |->
      (out_reg.object_last == (out_reg.payload_length == 64'd0)))
    else $error("Header end-of-object flag disagrees with its length.");

  a_header_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind == tlvd_pkg::KIND_HEADER) |->
      (out_reg.payload_byte == 8'd0))
    else $error("Header result carries a nonzero payload byte.");

  a_remaining_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (remaining != 64'd0))
    else $error("Payload phase entered with no bytes remaining.");

endmodule

[tb/testbench.sv]
// Self-checking testbench of the type-length-value stream deframer.
`timescale 1ns / 1ps

module testbench;

  localparam int TAG_BYTES = 4;
  localparam int RANDOM_BYTES = 1550;
  localparam int IDLE_LIMIT = 1000;

  typedef enum logic [1:0] {
    PH_TAG = 2'd0,
    PH_LEN = 2'd1,
    PH_PAYLOAD = 2'd2
  } parse_phase_t;

  typedef enum int {
    LEN_SHORT,
    LEN_WIDE16,
    LEN_WIDE64
  } len_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [31:0] type_tag;
  logic [63:0] payload_length;
  logic [7:0]  payload_byte;
  logic        object_last;

  tlv_stream_deframer_unit #(
    .TYPE_BYTES(TAG_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .type_tag(type_tag),
    .payload_length(payload_length),
    .payload_byte(payload_byte),
    .object_last(object_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  parse_phase_t parse_phase = PH_TAG;
  logic [31:0]  tag_acc = '0;
  logic [3:0]   field_cnt = '0;
  logic [7:0]   len_prefix = '0;
  logic [63:0]  len_acc = '0;
  logic [63:0]  payload_seen = '0;

  tlvd_pkg::result_t pending_results[$];
  int      error_count = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  int      stall_mode = 0;
  int      stall_mode_left = 0;
  int      stall_phase = 0;

  task automatic queue_result(input tlvd_pkg::result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic restart_object();
    parse_phase = PH_TAG;
    tag_acc = '0;
    field_cnt = '0;
    len_prefix = '0;
    len_acc = '0;
    payload_seen = '0;
  endtask

  task automatic close_header();
    tlvd_pkg::result_t hdr;
    hdr.kind = tlvd_pkg::KIND_HEADER;
    hdr.type_tag = tag_acc;
    hdr.payload_length = len_acc;
    hdr.payload_byte = 8'd0;
    hdr.object_last = (len_acc == 64'd0);
    queue_result(hdr);
    if (hdr.object_last) begin
      restart_object();
    end else begin
      parse_phase = PH_PAYLOAD;
      payload_seen = '0;
      field_cnt = '0;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    tlvd_pkg::result_t beat;
    logic [3:0]        wide_total;
    int                shift_amt;
    case (parse_phase)
      PH_LEN: begin
        if (field_cnt == 4'd0) begin
          len_prefix = b;
          if (b == tlvd_pkg::LEN_EXT16 || b == tlvd_pkg::LEN_EXT64) begin
            len_acc = '0;
            field_cnt = 4'd1;
          end else begin
            len_acc = {56'd0, b};
            close_header();
          end
        end else begin
          wide_total = (len_prefix == tlvd_pkg::LEN_EXT16) ? tlvd_pkg::EXT16_BYTES + 4'd1
                                                           : tlvd_pkg::EXT64_BYTES + 4'd1;
          shift_amt = ((field_cnt - 1) & 7) * 8;
          len_acc = len_acc | ({56'd0, b} << shift_amt);
          field_cnt = field_cnt + 4'd1;
          if (field_cnt >= wide_total) begin
            close_header();
          end
        end
      end
      PH_PAYLOAD: begin
        payload_seen = payload_seen + 64'd1;
        beat.kind = tlvd_pkg::KIND_PAYLOAD;
        beat.type_tag = tag_acc;
        beat.payload_length = len_acc;
        beat.payload_byte = b;
        beat.object_last = (payload_seen >= len_acc);
        queue_result(beat);
        if (beat.object_last) begin
          restart_object();
        end
      end
      default: begin
        parse_phase = PH_TAG;
        shift_amt = (field_cnt & 3) * 8;
        tag_acc = tag_acc | ({24'd0, b} << shift_amt);
        field_cnt = field_cnt + 4'd1;
        if (field_cnt >= TAG_BYTES) begin
          parse_phase = PH_LEN;
          field_cnt = '0;
          len_prefix = '0;
          len_acc = '0;
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (data_stall);
    burst_left--;
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_object(input logic [31:0] tag, input len_form_t form,
                             input logic [63:0] len, input logic [63:0] body_bytes);
    logic [63:0] n;
    for (int i = 0; i < TAG_BYTES; i++) begin
      send_byte(tag[8*i +: 8]);
    end
    case (form)
      LEN_SHORT: send_byte(len[7:0]);
      LEN_WIDE16: begin
        send_byte(tlvd_pkg::LEN_EXT16);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
      end
      default: begin
        send_byte(tlvd_pkg::LEN_EXT64);
        for (int i = 0; i < 8; i++) begin
          send_byte(len[8*i +: 8]);
        end
      end
    endcase
    for (n = 64'd0; n < body_bytes; n++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_short_lengths();
    send_object(32'hFFFF_FFFF, LEN_SHORT, 64'd0, 64'd0);
    send_object(32'h0000_0000, LEN_SHORT, 64'd1, 64'd1);
    send_object(32'h1234_5678, LEN_SHORT, 64'd2, 64'd2);
  endtask

  task automatic test_zero_wide_lengths();
    send_object(32'hA5A5_5A5A, LEN_WIDE16, 64'd0, 64'd0);
    send_object(32'h5A5A_A5A5, LEN_WIDE64, 64'd0, 64'd0);
  endtask

  task automatic test_high_prefix();
    send_object(32'h8000_0001, LEN_SHORT, 64'd128, 64'd128);
  endtask

  task automatic test_random_stream();
    int          start_count;
    int          sel;
    len_form_t   form;
    logic [63:0] len;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(0, 12));
      end else if (sel < 55) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(13, 125));
      end else if (sel < 60) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(128, 255));
      end else if (sel < 78) begin
        form = LEN_WIDE16;
        len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(256, 300))
                                          : 64'($urandom_range(0, 40));
      end else begin
        form = LEN_WIDE64;
        len = 64'($urandom_range(0, 40));
      end
      send_object($urandom, form, len, len);
    end
  endtask

  task automatic test_full_wide_length();
    send_object($urandom, LEN_WIDE64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((data_valid && !data_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    tlvd_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat, kind %0d", $time, kind);
        end else begin
          want = pending_results.pop_front();
          if (want.kind !== kind || want.type_tag !== type_tag ||
              want.payload_length !== payload_length || want.payload_byte !== payload_byte ||
              want.object_last !== object_last) begin
            error_count++;
            $display("%0t: kind exp %0d got %0d, type_tag exp %h got %h", $time,
                     want.kind, kind, want.type_tag, type_tag);
            $display("%0t: payload_length exp %h got %h", $time,
                     want.payload_length, payload_length);
            $display("%0t: payload_byte exp %h got %h, object_last exp %0d got %0d", $time,
                     want.payload_byte, payload_byte, want.object_last, object_last);
          end
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 200);
      end else begin
        stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 99) < 30);
        2: result_stall <= ($urandom_range(0, 99) < 70);
        default: result_stall <= stall_phase[2];
      endcase
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_lengths();
    test_zero_wide_lengths();
    test_high_prefix();
    test_random_stream();
    test_full_wide_length();
    data_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
